// ----- rtl/core/cht_pkg.sv -----
// Shared constants, types and codes for the cache tag lookup engine.
`timescale 1ns / 1ps
package cht_pkg;

    // Store geometry
    localparam int MAX_BLOCKS = 256;
    localparam int SET_WAYS   = 4;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int WAY_W      = $clog2(SET_WAYS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int TAG_W      = 32;
    localparam int AGE_W      = 8;
    localparam int ADDR_W     = 32;
    localparam int NUM_W      = 32;

    // Configuration register widths and limits
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam logic [3:0] BLOCKS_LOG2_MIN = 4'd2;
    localparam logic [3:0] BLOCKS_LOG2_MAX = 4'(IDX_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_LOG2  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORGANIZATION = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 2'd3;

    // Organization codes
    localparam logic [1:0] ORG_DIRECT = 2'd0;
    localparam logic [1:0] ORG_SET    = 2'd1;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam logic [NUM_W-1:0] NUM_MAX = '1;

    // Lookup job handed from the top level to the sequencer
    typedef struct packed {
        logic [TAG_W-1:0] blk;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] n_m1;
        logic             lru;
    } job_t;

    // Store access request
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic             wr_tag_en;
        logic [IDX_W-1:0] wr_idx;
        logic [TAG_W-1:0] wr_tag;
        logic [AGE_W-1:0] wr_age;
    } mem_req_t;

    // Registered store read data
    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } mem_rsp_t;

    // Finished lookup
    typedef struct packed {
        logic valid;
        logic hit;
    } res_t;

endpackage

// ----- rtl/core/cache_hit_miss_tag_engine.sv -----
// Top level of the cache tag lookup engine: config, group select, result register.
`timescale 1ns / 1ps
// Each accepted byte address is reduced to a block address, looked up in a
// tag store of 256 entries and reported as hit or miss with a saturating
// access number. Direct mapped, four-way set associative and fully
// associative layouts are selected at run time, with FIFO or LRU eviction.
// The store has one read port and is walked one entry per cycle: a scan
// pass over the n entries of the addressed group (n = 1, 4, or the block
// count up to 256), then an update pass of the same length for a miss or an
// LRU hit. Each pass compares the registered read data of one entry while
// the read of the next entry is issued. A new address is taken only after
// the previous lookup has handed its result to the output register, where
// a finished result waits while the next address is taken.
// Valid flags clear at reset; no clearing pass is needed.
module cache_hit_miss_tag_engine
    import cht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] byte_address
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata    // [0] is_hit, [32:1] access_number, zero pad
);

    logic [3:0]       offset_bits_reg;
    logic [3:0]       blocks_log2_reg;
    logic [1:0]       organization_reg;
    logic             policy_reg;

    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [NUM_W-1:0] out_num_reg;
    logic [NUM_W-1:0] acc_cnt_reg, acc_cnt_next;

    logic [TAG_W-1:0] blk;
    logic [3:0]       bl;
    logic [IDX_W-1:0] blk_mask;
    job_t             job;
    mem_req_t         req;
    mem_rsp_t         rsp;
    res_t             res;
    logic             seq_ready;
    logic             res_take;
    logic             start_en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg  <= 4'd4;
            blocks_log2_reg  <= 4'd8;
            organization_reg <= ORG_DIRECT;
            policy_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_OFFSET_BITS:  offset_bits_reg  <= cfg_wdata[3:0];
                REG_BLOCKS_LOG2:  blocks_log2_reg  <= cfg_wdata[3:0];
                REG_ORGANIZATION: organization_reg <= cfg_wdata[1:0];
                REG_POLICY:       policy_reg       <= cfg_wdata[0];
                default:          policy_reg       <= policy_reg;
            endcase
        end
    end

    // Block address and group placement
    always_comb
    begin
        blk = s_tdata >> offset_bits_reg;
        if (blocks_log2_reg < BLOCKS_LOG2_MIN)
        begin
            bl = BLOCKS_LOG2_MIN;
        end
        else if (blocks_log2_reg > BLOCKS_LOG2_MAX)
        begin
            bl = BLOCKS_LOG2_MAX;
        end
        else
        begin
            bl = blocks_log2_reg;
        end
        blk_mask = IDX_W'(({{IDX_W{1'b0}}, 1'b1} << bl) - 1'b1);

        job.blk = blk;
        job.lru = policy_reg && (organization_reg != ORG_DIRECT);
        case (organization_reg)
            ORG_DIRECT:
            begin
                job.base = blk[IDX_W-1:0] & blk_mask;
                job.n_m1 = '0;
            end
            ORG_SET:
            begin
                job.base = (blk[IDX_W-1:0] & (blk_mask >> WAY_W)) << WAY_W;
                job.n_m1 = IDX_W'(SET_WAYS - 1);
            end
            default:
            begin
                job.base = '0;
                job.n_m1 = blk_mask;
            end
        endcase
    end

    assign s_tready = seq_ready;
    assign start_en = s_tvalid && seq_ready;

    cht_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start_en (start_en),
        .job      (job),
        .ready    (seq_ready),
        .req      (req),
        .rsp      (rsp),
        .res      (res),
        .res_take (res_take)
    );

    cht_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Saturating access counter and output register
    assign res_take     = !out_valid_reg || m_tready;
    assign acc_cnt_next = (acc_cnt_reg == NUM_MAX) ? acc_cnt_reg : acc_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            acc_cnt_reg   <= '0;
        end
        else if (res.valid && res_take)
        begin
            out_valid_reg <= 1'b1;
            acc_cnt_reg   <= acc_cnt_next;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_take)
        begin
            out_hit_reg <= res.hit;
            out_num_reg <= acc_cnt_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_num_reg, out_hit_reg};

endmodule

// ----- rtl/core/cht_store.sv -----
// Tag and age memories with per-entry valid flags.
`timescale 1ns / 1ps
module cht_store
    import cht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output mem_rsp_t rsp
);

    logic [TAG_W-1:0]      tag_mem [MAX_BLOCKS];
    logic [AGE_W-1:0]      age_mem [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [TAG_W-1:0]      tag_q_reg;
    logic [AGE_W-1:0]      age_q_reg;
    logic                  valid_q_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            age_mem[req.wr_idx] <= req.wr_age;
        end
        if (req.wr_tag_en)
        begin
            tag_mem[req.wr_idx] <= req.wr_tag;
        end
        if (req.rd_en)
        begin
            tag_q_reg   <= tag_mem[req.rd_idx];
            age_q_reg   <= age_mem[req.rd_idx];
            valid_q_reg <= valid_reg[req.rd_idx];
        end
    end

    // Valid flags, cleared at reset, set when a tag is written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_tag_en)
        begin
            valid_reg[req.wr_idx] <= 1'b1;
        end
    end

    assign rsp.valid = valid_q_reg;
    assign rsp.tag   = tag_q_reg;
    assign rsp.age   = age_q_reg;

endmodule

// ----- rtl/core/cht_seq.sv -----
// Lookup sequencer: scan pass and update pass over one group of entries.
`timescale 1ns / 1ps
module cht_seq
    import cht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start_en,
    input  job_t     job,
    output logic     ready,
    output mem_req_t req,
    input  mem_rsp_t rsp,
    output res_t     res,
    input  logic     res_take
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_RESULT = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rdv_reg, rdv_next;
    logic [IDX_W-1:0] doff_reg, doff_next;
    logic [TAG_W-1:0] blk_reg, blk_next;
    logic [IDX_W-1:0] base_reg, base_next;
    logic [IDX_W-1:0] nm1_reg, nm1_next;
    logic             lru_reg, lru_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] hoff_reg, hoff_next;
    logic [AGE_W-1:0] hage_reg, hage_next;
    logic             inv_reg, inv_next;
    logic [IDX_W-1:0] ioff_reg, ioff_next;
    logic [AGE_W-1:0] bage_reg, bage_next;
    logic [IDX_W-1:0] boff_reg, boff_next;
    logic [IDX_W-1:0] voff_reg, voff_next;

    logic issue;
    logic last;
    logic match;

    assign issue = (cnt_reg <= {1'b0, nm1_reg});
    assign last  = rdv_reg && (doff_reg == nm1_reg);
    assign match = rsp.valid && (rsp.tag == blk_reg);

    // Sequencer next state and shared compare/update unit
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rdv_next   = rdv_reg;
        doff_next  = doff_reg;
        blk_next   = blk_reg;
        base_next  = base_reg;
        nm1_next   = nm1_reg;
        lru_next   = lru_reg;
        found_next = found_reg;
        hoff_next  = hoff_reg;
        hage_next  = hage_reg;
        inv_next   = inv_reg;
        ioff_next  = ioff_reg;
        bage_next  = bage_reg;
        boff_next  = boff_reg;
        voff_next  = voff_reg;

        req           = '0;
        req.rd_idx    = base_reg + cnt_reg[IDX_W-1:0];
        req.wr_idx    = base_reg + doff_reg;
        req.wr_tag    = blk_reg;
        req.wr_age    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start_en)
                begin
                    blk_next   = job.blk;
                    base_next  = job.base;
                    nm1_next   = job.n_m1;
                    lru_next   = job.lru;
                    cnt_next   = '0;
                    rdv_next   = 1'b0;
                    found_next = 1'b0;
                    inv_next   = 1'b0;
                    bage_next  = '0;
                    boff_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                req.rd_en = issue;
                rdv_next  = issue;
                doff_next = cnt_reg[IDX_W-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    // first match, first free entry, oldest valid entry
                    if (match && !found_reg)
                    begin
                        found_next = 1'b1;
                        hoff_next  = doff_reg;
                        hage_next  = rsp.age;
                    end
                    if (!rsp.valid && !inv_reg)
                    begin
                        inv_next  = 1'b1;
                        ioff_next = doff_reg;
                    end
                    if (rsp.valid && (rsp.age > bage_reg))
                    begin
                        bage_next = rsp.age;
                        boff_next = doff_reg;
                    end
                end
                if (last)
                begin
                    voff_next = inv_next ? ioff_next : boff_next;
                    cnt_next  = '0;
                    rdv_next  = 1'b0;
                    if (found_next && !lru_reg)
                    begin
                        state_next = ST_RESULT;
                    end
                    else
                    begin
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                req.rd_en = issue;
                rdv_next  = issue;
                doff_next = cnt_reg[IDX_W-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (rdv_reg)
                begin
                    if (found_reg)
                    begin
                        // LRU hit: move entry to front, age the younger ones
                        if (doff_reg == hoff_reg)
                        begin
                            req.wr_en = 1'b1;
                        end
                        else if (rsp.valid && (rsp.age < hage_reg))
                        begin
                            req.wr_en  = 1'b1;
                            req.wr_age = rsp.age + 1'b1;
                        end
                    end
                    else
                    begin
                        // miss: fill the victim, age every other valid entry below the maximum age
                        if (doff_reg == voff_reg)
                        begin
                            req.wr_en     = 1'b1;
                            req.wr_tag_en = 1'b1;
                        end
                        else if (rsp.valid && (rsp.age != AGE_MAX))
                        begin
                            req.wr_en  = 1'b1;
                            req.wr_age = rsp.age + 1'b1;
                        end
                    end
                end
                if (last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            rdv_reg   <= 1'b0;
            found_reg <= 1'b0;
            inv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rdv_reg   <= rdv_next;
            found_reg <= found_next;
            inv_reg   <= inv_next;
        end
    end

    // Job and scan payload
    always_ff @(posedge clk)
    begin
        doff_reg <= doff_next;
        blk_reg  <= blk_next;
        base_reg <= base_next;
        nm1_reg  <= nm1_next;
        lru_reg  <= lru_next;
        hoff_reg <= hoff_next;
        hage_reg <= hage_next;
        ioff_reg <= ioff_next;
        bage_reg <= bage_next;
        boff_reg <= boff_next;
        voff_reg <= voff_next;
    end

    assign ready     = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_RESULT);
    assign res.hit   = found_reg;

endmodule

// ----- rtl/core/cht_checker.sv -----
// Port-level checks for the cache tag lookup engine, bound to the top level.
`timescale 1ns / 1ps
module cht_checker
    import cht_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result holds its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

    // Access numbers start at one and never show zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32:1] != 32'd0)
    else $error("access number is zero");

    // One lookup at a time: no new address right after a transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

    // Consecutive results carry differing or saturated access numbers
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready ##1 m_tvalid |->
            (m_tdata[32:1] != $past(m_tdata[32:1])) || (m_tdata[32:1] == 32'hFFFFFFFF))
    else $error("access number repeated");

endmodule

bind cache_hit_miss_tag_engine cht_checker u_cht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/cache_tag_checker.sv -----
// Checker for the cache tag engine: predicts every lookup and compares each result transfer.
`timescale 1ns / 1ps
module cache_tag_checker
    import cht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] byte_address
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,   // [0] is_hit, [32:1] access_number, zero pad
    output int                    miscompares,
    output int                    outcomes_due,
    output int                    hits_seen,
    output int                    lookups_seen
);

    typedef struct packed {
        logic             hit;
        logic [NUM_W-1:0] num;
    } outcome_t;

    // Shadow copy of the tag store and the register file
    logic [TAG_W-1:0] tag_mem [MAX_BLOCKS];
    logic             vld_mem [MAX_BLOCKS];
    logic [AGE_W-1:0] age_mem [MAX_BLOCKS];
    logic [NUM_W-1:0] access_cnt;
    logic [3:0]       off_cfg;
    logic [3:0]       blog_cfg;
    logic [1:0]       org_cfg;
    logic             pol_cfg;

    outcome_t outcome_q [$];
    outcome_t want;
    logic     now_hit;
    int       idx_i;
    int       errs;
    int       hits;
    int       lookups;

    // Look one byte address up in the shadow store; updates ages and fills on a miss.
    function automatic logic lookup_block(input logic [ADDR_W-1:0] addr);
        logic [TAG_W-1:0] blk;
        logic [AGE_W-1:0] hit_age;
        logic [AGE_W-1:0] best;
        logic             lru;
        int               bl;
        int               nblk;
        int               n;
        int               base;
        int               hit_idx;
        int               victim;
        int               k;
        int               i;

        blk = addr >> off_cfg;
        bl  = int'(blog_cfg);
        if (bl < int'(BLOCKS_LOG2_MIN))
            bl = int'(BLOCKS_LOG2_MIN);
        if (bl > int'(BLOCKS_LOG2_MAX))
            bl = int'(BLOCKS_LOG2_MAX);
        nblk = 1 << bl;

        // Group selection; codes 2 and 3 both mean one group of all blocks
        if (org_cfg == ORG_DIRECT)
        begin
            n    = 1;
            base = int'(blk % TAG_W'(nblk));
        end
        else if (org_cfg == ORG_SET)
        begin
            n    = SET_WAYS;
            base = int'(blk % TAG_W'(nblk / SET_WAYS)) * SET_WAYS;
        end
        else
        begin
            n    = nblk;
            base = 0;
        end
        lru = pol_cfg && (org_cfg != ORG_DIRECT);

        // Lowest matching entry wins
        hit_idx = -1;
        for (i = 0; i < n; i++)
        begin
            if (hit_idx < 0 && vld_mem[base + i] && tag_mem[base + i] == blk)
                hit_idx = base + i;
        end

        if (hit_idx >= 0)
        begin
            if (lru)
            begin
                hit_age = age_mem[hit_idx];
                for (i = 0; i < n; i++)
                begin
                    k = base + i;
                    if (k != hit_idx && vld_mem[k] && age_mem[k] < hit_age)
                        age_mem[k] = age_mem[k] + 1'b1;
                end
                age_mem[hit_idx] = '0;
            end
            return 1'b1;
        end

        // Miss: lowest free entry, else oldest entry (lowest index on a tie)
        victim = -1;
        for (i = 0; i < n; i++)
        begin
            if (victim < 0 && !vld_mem[base + i])
                victim = i;
        end
        if (victim < 0)
        begin
            best   = '0;
            victim = 0;
            for (i = 0; i < n; i++)
            begin
                if (age_mem[base + i] > best)
                begin
                    best   = age_mem[base + i];
                    victim = i;
                end
            end
        end

        for (i = 0; i < n; i++)
        begin
            k = base + i;
            if (i != victim && vld_mem[k] && age_mem[k] != AGE_MAX)
                age_mem[k] = age_mem[k] + 1'b1;
        end
        tag_mem[base + victim] = blk;
        vld_mem[base + victim] = 1'b1;
        age_mem[base + victim] = '0;
        return 1'b0;
    endfunction

    // Watch register writes, input and result transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (idx_i = 0; idx_i < MAX_BLOCKS; idx_i++)
            begin
                vld_mem[idx_i] = 1'b0;
                age_mem[idx_i] = '0;
            end
            access_cnt = '0;
            off_cfg    = 4'd4;
            blog_cfg   = 4'd8;
            org_cfg    = ORG_DIRECT;
            pol_cfg    = 1'b0;
            outcome_q.delete();
            errs       = 0;
            hits       = 0;
            lookups    = 0;
            miscompares  <= 0;
            outcomes_due <= 0;
            hits_seen    <= 0;
            lookups_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_OFFSET_BITS:  off_cfg  = cfg_wdata;
                    REG_BLOCKS_LOG2:  blog_cfg = cfg_wdata;
                    REG_ORGANIZATION: org_cfg  = cfg_wdata[1:0];
                    REG_POLICY:       pol_cfg  = cfg_wdata[0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                now_hit = lookup_block(s_tdata);
                if (access_cnt != NUM_MAX)
                    access_cnt = access_cnt + 1'b1;
                want.hit = now_hit;
                want.num = access_cnt;
                outcome_q.insert(outcome_q.size(), want);
                lookups++;
                if (now_hit)
                    hits++;
            end

            if (m_tvalid && m_tready)
            begin
                if (outcome_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected result transfer: expected none, got hit=%0b num=%0d",
                             $time, m_tdata[0], m_tdata[32:1]);
                end
                else
                begin
                    want = outcome_q[0];
                    outcome_q.delete(0);
                    if (want.hit !== m_tdata[0] || want.num !== m_tdata[32:1])
                    begin
                        errs++;
                        $display("%0t: result mismatch: expected hit=%0b num=%0d, got hit=%0b num=%0d",
                                 $time, want.hit, want.num, m_tdata[0], m_tdata[32:1]);
                    end
                end
            end

            miscompares  <= errs;
            outcomes_due <= outcome_q.size();
            hits_seen    <= hits;
            lookups_seen <= lookups;
        end
    end

endmodule

// ----- bench/cache_hit_miss_tag_engine_tb.sv -----
// Testbench top for the cache tag engine: clock, reset, register setup, stimulus and verdict.
`timescale 1ns / 1ps
module cache_hit_miss_tag_engine_tb;
    import cht_pkg::*;

    localparam logic [1:0] ORG_FULL     = 2'd2;
    localparam logic [1:0] ORG_FULL_ALT = 2'd3;
    localparam logic       POL_FIFO     = 1'b0;
    localparam logic       POL_LRU      = 1'b1;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int HOLD_CYCLES    = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [39:0]           m_tdata;

    int miscompares;
    int outcomes_due;
    int hits_seen;
    int lookups_seen;

    int  quiet_cycles;
    int  settings_run;
    int  tx_gap_pct;
    int  rx_idle_pct;
    bit  hold_req;
    bit  hold_done;

    logic [ADDR_W-1:0] addr_pool [$];
    logic [ADDR_W-1:0] last_addr;
    logic [ADDR_W-1:0] corner_addrs [0:11];
    logic [ADDR_W-1:0] lru_addrs [0:7];

    cache_hit_miss_tag_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    cache_tag_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .miscompares  (miscompares),
        .outcomes_due (outcomes_due),
        .hits_seen    (hits_seen),
        .lookups_seen (lookups_seen)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog: ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random back-pressure bursts, plus one long hold when asked
    initial
    begin
        m_tready <= 1'b0;
        hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one address, with an optional idle burst first; returns after the transfer
    task automatic offer_access(input logic [ADDR_W-1:0] addr);
        int gap;
        if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct)
        begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        last_addr = addr;
    endtask

    // Stop offering and wait until every lookup has reported
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outcomes_due != 0)
            @(posedge clk);
    endtask

    // Write all four registers back to back; only called with the engine idle
    task automatic apply_setting(input logic [3:0] off, input logic [3:0] blog,
                                 input logic [1:0] org, input logic pol);
        cfg_we    <= 1'b1;
        cfg_idx   <= REG_OFFSET_BITS;
        cfg_wdata <= off;
        @(posedge clk);
        cfg_idx   <= REG_BLOCKS_LOG2;
        cfg_wdata <= blog;
        @(posedge clk);
        cfg_idx   <= REG_ORGANIZATION;
        cfg_wdata <= {2'b00, org};
        @(posedge clk);
        cfg_idx   <= REG_POLICY;
        cfg_wdata <= {3'b000, pol};
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_run++;
    endtask

    // One setting with random traffic drawn mostly from a working set about
    // 1.5x the cache size, so hits, conflicts and evictions all show up
    task automatic run_traffic(input logic [3:0] off, input logic [3:0] blog,
                               input logic [1:0] org, input logic pol, input int count,
                               input int tx_pct, input int rx_pct, input bit squeeze);
        logic [ADDR_W-1:0] blk;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] low_mask;
        int                bl;
        int                nblk;
        int                pick;

        apply_setting(off, blog, org, pol);
        tx_gap_pct  = tx_pct;
        rx_idle_pct <= rx_pct;
        if (squeeze)
            hold_req <= 1'b1;

        bl = int'(blog);
        if (bl < int'(BLOCKS_LOG2_MIN))
            bl = int'(BLOCKS_LOG2_MIN);
        if (bl > int'(BLOCKS_LOG2_MAX))
            bl = int'(BLOCKS_LOG2_MAX);
        nblk = 1 << bl;

        addr_pool.delete();
        repeat (nblk + nblk / 2 + 2)
        begin
            if ($urandom_range(0, 3) == 0)
                blk = $urandom();
            else
                blk = $urandom_range(0, 3) * nblk + $urandom_range(0, nblk - 1);
            addr_pool.insert(addr_pool.size(), blk << off);
        end
        low_mask = (32'd1 << off) - 1;

        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                addr = $urandom();
            else if (pick < 22)
                addr = (last_addr & ~low_mask) | ($urandom() & low_mask);
            else
                addr = addr_pool[$urandom_range(0, addr_pool.size() - 1)]
                       | ($urandom() & low_mask);
            offer_access(addr);
        end
        wait_drained();
    endtask

    // Main sequence
    initial
    begin
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_idx     <= REG_OFFSET_BITS;
        cfg_wdata   <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        hold_req    <= 1'b0;
        rx_idle_pct <= 0;
        tx_gap_pct   = 0;
        settings_run = 0;
        last_addr    = '0;

        corner_addrs = '{32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFFF, 32'hFFFF_FFF0,
                         32'h0000_1000, 32'h0000_0000, 32'h0000_1008, 32'hAAAA_AAAA,
                         32'h5555_5555, 32'hAAAA_AAA5, 32'h8000_0000, 32'h7FFF_FFFF};
        // Fully associative, four blocks, LRU: the re-touched block 0 must survive
        lru_addrs = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd0, 32'd4, 32'd1, 32'd0};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting (direct mapped, 256 blocks, 16-byte blocks)
        foreach (corner_addrs[i])
            offer_access(corner_addrs[i]);
        wait_drained();

        // Directed: LRU ordering in a tiny fully associative cache
        apply_setting(4'd0, 4'd2, ORG_FULL, POL_LRU);
        foreach (lru_addrs[i])
            offer_access(lru_addrs[i]);
        wait_drained();

        // Random traffic over a spread of settings; the store is never cleared between them
        run_traffic(4'd0,  4'd2,  ORG_DIRECT,   POL_LRU,  100, 0,  0,  1'b1);
        run_traffic(4'd12, 4'd2,  ORG_SET,      POL_FIFO, 100, 20, 5,  1'b0);
        run_traffic(4'd15, 4'd3,  ORG_SET,      POL_LRU,  120, 5,  10, 1'b0);
        run_traffic(4'd13, 4'd0,  ORG_FULL,     POL_LRU,  100, 30, 3,  1'b0);
        run_traffic(4'd1,  4'd1,  ORG_FULL_ALT, POL_FIFO, 100, 10, 10, 1'b0);
        run_traffic(4'd4,  4'd4,  ORG_SET,      POL_FIFO, 120, 0,  0,  1'b0);
        run_traffic(4'd7,  4'd5,  ORG_FULL,     POL_FIFO, 100, 15, 5,  1'b0);
        run_traffic(4'd2,  4'd6,  ORG_DIRECT,   POL_FIFO, 140, 10, 10, 1'b0);
        run_traffic(4'd9,  4'd15, ORG_SET,      POL_LRU,  140, 5,  5,  1'b0);
        run_traffic(4'd6,  4'd8,  ORG_FULL,     POL_LRU,  40,  10, 10, 1'b0);
        run_traffic(4'd3,  4'd5,  ORG_FULL_ALT, POL_LRU,  100, 20, 5,  1'b0);
        run_traffic(4'd11, 4'd7,  ORG_SET,      POL_FIFO, 60,  5,  5,  1'b0);
        // Last stretch runs with no idling on either side
        run_traffic(4'd0,  4'd8,  ORG_DIRECT,   POL_LRU,  80,  0,  0,  1'b0);

        // Let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d accesses (%0d hits, %0d misses) over %0d register settings.",
                 lookups_seen, hits_seen, lookups_seen - hits_seen, settings_run + 1);
        $display("%s%s", "Settings spanned direct, four-way and fully associative layouts, ",
                 "FIFO and LRU, offsets 0 to 15 and out-of-range block counts.");
        if (miscompares == 0 && outcomes_due == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", miscompares, outcomes_due);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
